### src/dotq_pkg.sv
// shared types, codes and default sizes for the deadline ordered task queue
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package dotq_pkg;

    localparam int DEPTH_DEF         = 16;
    localparam int ID_BITS_DEF       = 8;
    localparam int DEADLINE_BITS_DEF = 16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

`default_nettype wire

### src/dotq_cell.sv
// one slot of the sorted queue: holds an entry and moves it to a neighbor
// depends on dotq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dotq_cell #(
    parameter int ID_BITS       = dotq_pkg::ID_BITS_DEF,
    parameter int DEADLINE_BITS = dotq_pkg::DEADLINE_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  dotq_pkg::t_cell_ctl     i_ctl,
    input  wire [ID_BITS-1:0]       i_new_id,
    input  wire [DEADLINE_BITS-1:0] i_new_dl,
    input  wire                     i_left_valid,
    input  wire [ID_BITS-1:0]       i_left_id,
    input  wire [DEADLINE_BITS-1:0] i_left_dl,
    input  wire                     i_left_before,
    input  wire                     i_right_valid,
    input  wire [ID_BITS-1:0]       i_right_id,
    input  wire [DEADLINE_BITS-1:0] i_right_dl,
    input  wire                     i_pull_right,
    output logic                    o_valid,
    output logic [ID_BITS-1:0]      o_id,
    output logic [DEADLINE_BITS-1:0] o_dl,
    output logic                    o_before,
    output logic                    o_match
);

    logic                     r_valid, n_valid;
    logic [ID_BITS-1:0]       r_id, n_id;
    logic [DEADLINE_BITS-1:0] r_dl, n_dl;

    // new entry belongs in front of this slot
    assign o_before = !r_valid || (r_dl > i_new_dl);
    assign o_match  = r_valid && (r_id == i_new_id);

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_dl    = r_dl;
        if (i_ctl.ins) begin
            if (i_left_before) begin
                n_valid = i_left_valid;
                n_id    = i_left_id;
                n_dl    = i_left_dl;
            end else if (o_before) begin
                n_valid = 1'b1;
                n_id    = i_new_id;
                n_dl    = i_new_dl;
            end
        end else if (i_ctl.del && i_pull_right) begin
            n_valid = i_right_valid;
            n_id    = i_right_id;
            n_dl    = i_right_dl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_id <= n_id;
        r_dl <= n_dl;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_dl    = r_dl;

endmodule

`default_nettype wire

### src/dotq_prefix_or.sv
// log-depth prefix or across the row of match flags
// no dependencies beyond dotq_pkg defaults at the top level
`timescale 1ns / 1ps
`default_nettype none

module dotq_prefix_or #(
    parameter int N = dotq_pkg::DEPTH_DEF
) (
    input  wire [N-1:0]  i_bits,
    output logic [N-1:0] o_prefix
);

    localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] s [0:LEVELS];

    assign s[0] = i_bits;

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        for (genvar k = 0; k < N; k++) begin : g_bit
            if (k >= (1 << l)) begin : g_or
                assign s[l+1][k] = s[l][k] | s[l][k - (1 << l)];
            end else begin : g_pass
                assign s[l+1][k] = s[l][k];
            end
        end
    end

    assign o_prefix = s[LEVELS];

endmodule

`default_nettype wire

### src/deadline_ordered_task_queue.sv
// top level of the earliest-deadline-first queue: row of dotq_cell slots
// depends on dotq_pkg, dotq_cell, dotq_prefix_or
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-----------------------------------------
//  command   | in        | i_start, o_busy      | i_opcode, i_task_id, i_deadline
//  result    | out       | o_done (strobe)      | o_status, o_head_valid, o_head_task_id,
//            |           |                      | o_head_deadline, o_occupancy
//
//  one beat per cycle: a command taken at an edge updates every slot at that edge and
//  its result strobes on o_done during the next cycle, so commands may follow back to back
//  the limit is the combinational slot update: compare in every cell plus a log-depth
//  or over the delete match flags
//  reset is synchronous, active low; it empties the queue and holds busy high
//  the receiver cannot stall: every result lives for exactly the one o_done cycle
`timescale 1ns / 1ps
`default_nettype none

module deadline_ordered_task_queue #(
    parameter int DEPTH         = dotq_pkg::DEPTH_DEF,
    parameter int ID_BITS       = dotq_pkg::ID_BITS_DEF,
    parameter int DEADLINE_BITS = dotq_pkg::DEADLINE_BITS_DEF,
    localparam int CNT_W        = $clog2(DEPTH + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    output logic                     o_busy,
    input  wire                      i_opcode,
    input  wire [ID_BITS-1:0]        i_task_id,
    input  wire [DEADLINE_BITS-1:0]  i_deadline,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic                     o_head_valid,
    output logic [ID_BITS-1:0]       o_head_task_id,
    output logic [DEADLINE_BITS-1:0] o_head_deadline,
    output logic [CNT_W-1:0]         o_occupancy
);

    // per-slot views of the row
    logic [DEPTH-1:0]         w_valid;
    logic [ID_BITS-1:0]       w_id [0:DEPTH-1];
    logic [DEADLINE_BITS-1:0] w_dl [0:DEPTH-1];
    logic [DEPTH-1:0]         w_before;
    logic [DEPTH-1:0]         w_match;
    logic [DEPTH-1:0]         w_pull;   // a match sits at or in front of this slot

    logic                w_accept;
    logic                w_full;
    logic                w_found;
    dotq_pkg::t_cell_ctl w_ctl;

    logic                r_done;
    dotq_pkg::t_status   r_status, n_status;
    logic [CNT_W-1:0]    r_count, n_count;

    // busy only while reset is held; otherwise a beat can be taken every cycle
    assign o_busy   = !i_rst_n;
    assign w_accept = i_start && !o_busy;

    // slots stay packed from slot 0, so the last slot tells full
    assign w_full  = w_valid[DEPTH-1];
    assign w_found = w_pull[DEPTH-1];

    assign w_ctl.ins = w_accept && (dotq_pkg::t_op'(i_opcode) == dotq_pkg::OP_INSERT) && !w_full;
    assign w_ctl.del = w_accept && (dotq_pkg::t_op'(i_opcode) == dotq_pkg::OP_DELETE);

    // first match wins: every slot from it onward pulls from its right neighbor
    dotq_prefix_or #(
        .N(DEPTH)
    ) u_pfx (
        .i_bits  (w_match),
        .o_prefix(w_pull)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                     l_valid;
        logic [ID_BITS-1:0]       l_id;
        logic [DEADLINE_BITS-1:0] l_dl;
        logic                     l_before;
        logic                     r_valid_in;
        logic [ID_BITS-1:0]       r_id_in;
        logic [DEADLINE_BITS-1:0] r_dl_in;

        if (i == 0) begin : g_first
            // nothing shifts into the head from the left
            assign l_valid  = 1'b0;
            assign l_id     = '0;
            assign l_dl     = '0;
            assign l_before = 1'b0;
        end else begin : g_mid_l
            assign l_valid  = w_valid[i-1];
            assign l_id     = w_id[i-1];
            assign l_dl     = w_dl[i-1];
            assign l_before = w_before[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            // the tail empties when the row closes a gap
            assign r_valid_in = 1'b0;
            assign r_id_in    = '0;
            assign r_dl_in    = '0;
        end else begin : g_mid_r
            assign r_valid_in = w_valid[i+1];
            assign r_id_in    = w_id[i+1];
            assign r_dl_in    = w_dl[i+1];
        end

        dotq_cell #(
            .ID_BITS      (ID_BITS),
            .DEADLINE_BITS(DEADLINE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new_id     (i_task_id),
            .i_new_dl     (i_deadline),
            .i_left_valid (l_valid),
            .i_left_id    (l_id),
            .i_left_dl    (l_dl),
            .i_left_before(l_before),
            .i_right_valid(r_valid_in),
            .i_right_id   (r_id_in),
            .i_right_dl   (r_dl_in),
            .i_pull_right (w_pull[i]),
            .o_valid      (w_valid[i]),
            .o_id         (w_id[i]),
            .o_dl         (w_dl[i]),
            .o_before     (w_before[i]),
            .o_match      (w_match[i])
        );
    end

    // status and occupancy for the beat being taken
    always_comb begin
        n_status = dotq_pkg::ST_DONE;
        n_count  = r_count;
        if (w_accept) begin
            if (dotq_pkg::t_op'(i_opcode) == dotq_pkg::OP_INSERT) begin
                if (w_full) begin
                    n_status = dotq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end else begin
                if (w_found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = dotq_pkg::ST_NOMATCH;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done  <= w_accept;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // head is slot 0, already updated when the strobe shows
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_head_valid    = w_valid[0];
    assign o_head_task_id  = w_valid[0] ? w_id[0] : '0;
    assign o_head_deadline = w_valid[0] ? w_dl[0] : '0;
    assign o_occupancy     = r_count;

endmodule

`default_nettype wire

### src/dotq_checker.sv
// port-level checks for deadline_ordered_task_queue, bound to the top level
// depends on dotq_pkg and deadline_ordered_task_queue
`timescale 1ns / 1ps
`default_nettype none

module dotq_checker #(
    parameter int DEPTH         = dotq_pkg::DEPTH_DEF,
    parameter int ID_BITS       = dotq_pkg::ID_BITS_DEF,
    parameter int DEADLINE_BITS = dotq_pkg::DEADLINE_BITS_DEF,
    localparam int CNT_W        = $clog2(DEPTH + 1)
) (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_start,
    input wire                     o_busy,
    input wire                     o_done,
    input wire [1:0]               o_status,
    input wire                     o_head_valid,
    input wire [ID_BITS-1:0]       o_head_task_id,
    input wire [DEADLINE_BITS-1:0] o_head_deadline,
    input wire [CNT_W-1:0]         o_occupancy
);

    // every taken beat answers in the next cycle
    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_done)
        else $error("accepted beat got no result strobe");

    a_head_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_head_valid == (o_occupancy != '0)))
        else $error("head valid disagrees with occupancy");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == dotq_pkg::ST_FULL) |-> (o_occupancy == CNT_W'(DEPTH)))
        else $error("insert dropped while queue not full");

    // a dropped or unmatched beat leaves the queue as it was
    a_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(o_done) && (o_status != dotq_pkg::ST_DONE)
        |-> $stable(o_occupancy) && $stable(o_head_task_id) && $stable(o_head_deadline))
        else $error("failed beat changed the queue");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_occupancy <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

endmodule

bind deadline_ordered_task_queue dotq_checker #(
    .DEPTH        (DEPTH),
    .ID_BITS      (ID_BITS),
    .DEADLINE_BITS(DEADLINE_BITS)
) u_dotq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_head_valid   (o_head_valid),
    .o_head_task_id (o_head_task_id),
    .o_head_deadline(o_head_deadline),
    .o_occupancy    (o_occupancy)
);

`default_nettype wire

### tb/tb_deadline_ordered_task_queue.sv
// self-checking testbench for the deadline ordered task queue
// depends on dotq_pkg and deadline_ordered_task_queue; drives a directed table, then random beats
// every result beat is compared with a behavioral mirror of the sorted queue, or with its hand-written report
`timescale 1ns / 1ps

module tb_deadline_ordered_task_queue;

    localparam int DEPTH  = dotq_pkg::DEPTH_DEF;
    localparam int ID_W   = dotq_pkg::ID_BITS_DEF;
    localparam int DL_W   = dotq_pkg::DEADLINE_BITS_DEF;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_BEATS  = 1625;
    localparam int BURST_LEN     = 40;
    // slowest legal run is about 1650 beats, each after the longest gap; allow about four times that
    localparam int CYCLE_LIMIT   = 400000;

    // one result beat as the block reports it
    typedef struct packed {
        dotq_pkg::t_status status;
        logic              head_valid;
        logic [ID_W-1:0]   head_id;
        logic [DL_W-1:0]   head_dl;
        logic [CNT_W-1:0]  occupancy;
    } t_report;

    // one row of the directed table; pinned rows carry a hand-written report
    typedef struct packed {
        dotq_pkg::t_op   op;
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] dl;
        logic            pinned;
        t_report         report;
    } t_row;

    // flavor of a random burst
    typedef enum logic [1:0] {
        MOOD_FILL,
        MOOD_DRAIN,
        MOOD_MIXED,
        MOOD_NOISE
    } t_mood;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    logic             i_opcode;
    logic [ID_W-1:0]  i_task_id;
    logic [DL_W-1:0]  i_deadline;
    logic             o_done;
    logic [1:0]       o_status;
    logic             o_head_valid;
    logic [ID_W-1:0]  o_head_task_id;
    logic [DL_W-1:0]  o_head_deadline;
    logic [CNT_W-1:0] o_occupancy;

    // hand-written report that travels with the beat on the command inputs
    logic             pin_row;
    t_report          pin_report;

    // mirror of the queue: packed from slot 0 in ascending deadline order
    logic [DL_W-1:0]  mirror_dl [DEPTH];
    logic [ID_W-1:0]  mirror_id [DEPTH];
    int               mirror_count;

    t_report          due_reports [$];

    int               fail_count;
    int               cycle_count;
    int               n_insert;
    int               n_delete;
    int               n_full;
    int               n_nomatch;
    int               peak_count;
    logic             hurry;

    // directed table: empty-queue delete, extremes, ties at zero, duplicate ids,
    // fill to the brim, insert into a full queue, delete from the middle of a tie run
    t_row plan [DIRECTED_ROWS] = '{
        '{dotq_pkg::OP_DELETE, 8'h00, 16'h0000, 1'b1,
          '{dotq_pkg::ST_NOMATCH, 1'b0, 8'h00, 16'h0000, 5'd0}},
        '{dotq_pkg::OP_INSERT, 8'hFF, 16'hFFFF, 1'b1,
          '{dotq_pkg::ST_DONE,    1'b1, 8'hFF, 16'hFFFF, 5'd1}},
        '{dotq_pkg::OP_INSERT, 8'h00, 16'h0000, 1'b1,
          '{dotq_pkg::ST_DONE,    1'b1, 8'h00, 16'h0000, 5'd2}},
        '{dotq_pkg::OP_INSERT, 8'h5A, 16'h0000, 1'b1,
          '{dotq_pkg::ST_DONE,    1'b1, 8'h00, 16'h0000, 5'd3}},
        '{dotq_pkg::OP_DELETE, 8'h00, 16'hFFFF, 1'b1,
          '{dotq_pkg::ST_DONE,    1'b1, 8'h5A, 16'h0000, 5'd2}},
        '{dotq_pkg::OP_DELETE, 8'h00, 16'h0000, 1'b1,
          '{dotq_pkg::ST_NOMATCH, 1'b1, 8'h5A, 16'h0000, 5'd2}},
        '{dotq_pkg::OP_INSERT, 8'hA5, 16'h8000, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h5A, 16'h7FFF, 1'b0, '0},
        '{dotq_pkg::OP_DELETE, 8'h5A, 16'h1234, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h01, 16'h1234, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h02, 16'h1234, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h03, 16'h1234, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h04, 16'h0001, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h05, 16'hFFFE, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h06, 16'hFFFF, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h07, 16'h1234, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h08, 16'h0000, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h09, 16'h7FFF, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h0A, 16'h8000, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h0B, 16'h1234, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h0C, 16'h00FF, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h0D, 16'hFF00, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h0E, 16'h0000, 1'b0, '0},
        '{dotq_pkg::OP_DELETE, 8'h03, 16'hAAAA, 1'b0, '0},
        '{dotq_pkg::OP_INSERT, 8'h0F, 16'h1234, 1'b0, '0}
    };

    deadline_ordered_task_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_opcode        (i_opcode),
        .i_task_id       (i_task_id),
        .i_deadline      (i_deadline),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_head_valid    (o_head_valid),
        .o_head_task_id  (o_head_task_id),
        .o_head_deadline (o_head_deadline),
        .o_occupancy     (o_occupancy)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // apply one accepted command to the mirror and return the report it should produce
    function automatic t_report advance_queue(dotq_pkg::t_op op, logic [ID_W-1:0] id,
                                              logic [DL_W-1:0] dl);
        t_report r;
        int      pos;
        r.status = dotq_pkg::ST_DONE;
        pos      = 0;
        if (op == dotq_pkg::OP_INSERT) begin
            if (mirror_count >= DEPTH) begin
                r.status = dotq_pkg::ST_FULL;
            end else begin
                // equal deadlines stay in arrival order: skip past them
                while (pos < mirror_count && mirror_dl[pos] <= dl) pos++;
                for (int k = mirror_count; k > pos; k--) begin
                    mirror_dl[k] = mirror_dl[k-1];
                    mirror_id[k] = mirror_id[k-1];
                end
                mirror_dl[pos] = dl;
                mirror_id[pos] = id;
                mirror_count++;
            end
        end else begin
            // only the match nearest the head goes
            while (pos < mirror_count && mirror_id[pos] != id) pos++;
            if (pos >= mirror_count) begin
                r.status = dotq_pkg::ST_NOMATCH;
            end else begin
                for (int k = pos; k + 1 < mirror_count; k++) begin
                    mirror_dl[k] = mirror_dl[k+1];
                    mirror_id[k] = mirror_id[k+1];
                end
                mirror_count--;
            end
        end
        r.head_valid = (mirror_count > 0);
        r.head_id    = (mirror_count > 0) ? mirror_id[0] : '0;
        r.head_dl    = (mirror_count > 0) ? mirror_dl[0] : '0;
        r.occupancy  = CNT_W'(mirror_count);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // mostly short gaps, a few long ones; none at all during a hurried burst
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (hurry || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // small pool most of the time so duplicates and matches are common
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 7) return ID_W'($urandom_range(0, 7));
        return ID_W'($urandom_range(0, (1 << ID_W) - 1));
    endfunction

    function automatic logic [DL_W-1:0] pick_dl();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return (mirror_count > 0) ? mirror_dl[$urandom_range(0, mirror_count - 1)] : '0;
            3: return DL_W'($urandom_range(0, 15));
            default: return DL_W'($urandom_range(0, (1 << DL_W) - 1));
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_cmd(dotq_pkg::t_op op, logic [ID_W-1:0] id, logic [DL_W-1:0] dl,
                            logic pinned, t_report report);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start    <= 1'b1;
        i_opcode   <= op;
        i_task_id  <= id;
        i_deadline <= dl;
        pin_row    <= pinned;
        pin_report <= report;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    // result side: the block cannot be stalled, so every strobe is one beat
    always @(posedge i_clk) begin : result_monitor
        t_report seen;
        t_report want;
        t_report calc;
        if (i_rst_n) begin
            if (o_done) begin
                seen.status     = dotq_pkg::t_status'(o_status);
                seen.head_valid = o_head_valid;
                seen.head_id    = o_head_task_id;
                seen.head_dl    = o_head_deadline;
                seen.occupancy  = o_occupancy;
                if (due_reports.size() == 0) begin
                    $error("result beat with no command outstanding");
                    fail_count++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("status",        want.status,     seen.status);
                    check_field("head_valid",    want.head_valid, seen.head_valid);
                    check_field("head_task_id",  want.head_id,    seen.head_id);
                    check_field("head_deadline", want.head_dl,    seen.head_dl);
                    check_field("occupancy",     want.occupancy,  seen.occupancy);
                end
            end
            // command beat taken at this edge
            if (i_start && !o_busy) begin
                calc = advance_queue(dotq_pkg::t_op'(i_opcode), i_task_id, i_deadline);
                due_reports.push_back(pin_row ? pin_report : calc);
                if (dotq_pkg::t_op'(i_opcode) == dotq_pkg::OP_INSERT) n_insert++;
                else n_delete++;
                if (calc.status == dotq_pkg::ST_FULL) n_full++;
                if (calc.status == dotq_pkg::ST_NOMATCH) n_nomatch++;
                if (mirror_count > peak_count) peak_count = mirror_count;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("deadline_ordered_task_queue regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        t_mood           mood;
        dotq_pkg::t_op   op;
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] dl;

        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_opcode     = 1'b0;
        i_task_id    = '0;
        i_deadline   = '0;
        pin_row      = 1'b0;
        pin_report   = '0;
        mirror_count = 0;
        fail_count   = 0;
        cycle_count  = 0;
        n_insert     = 0;
        n_delete     = 0;
        n_full       = 0;
        n_nomatch    = 0;
        peak_count   = 0;
        hurry        = 1'b0;
        mood         = MOOD_MIXED;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_cmd(plan[r].op, plan[r].id, plan[r].dl, plan[r].pinned, plan[r].report);

        // random bursts, each with its own flavor and pace
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % BURST_LEN == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: mood = MOOD_FILL;
                    3, 4, 5: mood = MOOD_DRAIN;
                    6, 7, 8: mood = MOOD_MIXED;
                    default: mood = MOOD_NOISE;
                endcase
                hurry = ($urandom_range(0, 3) == 0);
            end
            case (mood)
                MOOD_FILL:  op = ($urandom_range(0, 99) < 15) ? dotq_pkg::OP_DELETE
                                                              : dotq_pkg::OP_INSERT;
                MOOD_DRAIN: op = ($urandom_range(0, 99) < 80) ? dotq_pkg::OP_DELETE
                                                              : dotq_pkg::OP_INSERT;
                default:    op = dotq_pkg::t_op'($urandom_range(0, 1));
            endcase
            if (mood == MOOD_NOISE) begin
                id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
                dl = DL_W'($urandom_range(0, (1 << DL_W) - 1));
            end else begin
                dl = pick_dl();
                // deletes mostly name a task that is actually queued
                if (op == dotq_pkg::OP_DELETE && mirror_count > 0 && $urandom_range(0, 3) != 0)
                    id = mirror_id[$urandom_range(0, mirror_count - 1)];
                else
                    id = pick_id();
            end
            send_cmd(op, id, dl, 1'b0, '0);
        end

        i_start <= 1'b0;
        pin_row <= 1'b0;

        // drain outstanding reports, then wait quietly for stray strobes
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("ran %0d inserts and %0d deletes; %0d dropped on a full queue,",
                 n_insert, n_delete, n_full);
        $display("%0d deletes unmatched; peak occupancy %0d of %0d over %0d cycles",
                 n_nomatch, peak_count, DEPTH, cycle_count);
        if (fail_count == 0) begin
            $display("deadline_ordered_task_queue regression: pass");
        end else begin
            $display("deadline_ordered_task_queue regression: fail");
        end
        $finish;
    end

endmodule
